FILE: rtl/core/rbr_pkg.sv
// package for the roi bilinear resize block: widths, codes and helpers
`default_nettype none
package rbr_pkg;
	localparam int MAX_WIDTH_D  = 256;
	localparam int MAX_HEIGHT_D = 256;
	localparam int OUT_SIDE_D   = 36;
	localparam int CFG_W        = 17;
	localparam int CFG_IDX_W    = 3;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_ROI_LEFT     = 3'd2,
		REG_ROI_TOP      = 3'd3,
		REG_ROI_SPAN_X   = 3'd4,
		REG_ROI_SPAN_Y   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_FRAME   = 2'd1,
		ST_BAD_REGION  = 2'd2,
		ST_OUTSIDE     = 2'd3
	} status_t;

	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_t;

	// clamped region, shared between the mapping and output stages
	typedef struct packed {
		status_t     status;
		logic [12:0] left;
		logic [12:0] top;
		logic [12:0] span_x;
		logic [12:0] span_y;
	} region_t;
endpackage
`default_nettype wire

FILE: rtl/core/rbr_region.sv
// configuration registers and region clamping with status
`default_nettype none
module rbr_region #(
	parameter int MAX_WIDTH  = rbr_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = rbr_pkg::MAX_HEIGHT_D
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [rbr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rbr_pkg::CFG_W-1:0]  cfg_data,
	output rbr_pkg::region_t                region,
	output logic [8:0]                      fw,
	output logic [8:0]                      fh
);
	import rbr_pkg::*;

	logic [8:0]         fw_q, fh_q;
	logic signed [16:0] left_q, top_q, spx_q, spy_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= '0; fh_q <= '0;
			left_q <= '0; top_q <= '0; spx_q <= '0; spy_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  fw_q   <= cfg_data[8:0];
				REG_FRAME_HEIGHT: fh_q   <= cfg_data[8:0];
				REG_ROI_LEFT:     left_q <= cfg_data;
				REG_ROI_TOP:      top_q  <= cfg_data;
				REG_ROI_SPAN_X:   spx_q  <= cfg_data;
				REG_ROI_SPAN_Y:   spy_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [17:0] ux, uy, rw, rh, uw, uh;
	logic               bad_frame;

	// clamp region to frame
	always_comb begin
		ux = left_q[16] ? 18'sd0 : {1'b0, left_q};
		uy = top_q[16]  ? 18'sd0 : {1'b0, top_q};
		rw = $signed({5'd0, fw_q, 4'd0}) - ux;
		rh = $signed({5'd0, fh_q, 4'd0}) - uy;
		uw = ($signed({spx_q[16], spx_q}) < rw) ? $signed({spx_q[16], spx_q}) : rw;
		uh = ($signed({spy_q[16], spy_q}) < rh) ? $signed({spy_q[16], spy_q}) : rh;
		bad_frame = (fw_q == 9'd0) || (fh_q == 9'd0) ||
			({23'd0, fw_q} > 32'(MAX_WIDTH)) || ({23'd0, fh_q} > 32'(MAX_HEIGHT));
		region = '0;
		if (bad_frame)
			region.status = ST_BAD_FRAME;
		else if (spx_q[16] || spx_q == 17'sd0 || spy_q[16] || spy_q == 17'sd0)
			region.status = ST_BAD_REGION;
		else if (uw <= 18'sd0 || uh <= 18'sd0)
			region.status = ST_OUTSIDE;
		else begin
			region.status = ST_OK;
			region.left   = ux[12:0];
			region.top    = uy[12:0];
			region.span_x = uw[12:0];
			region.span_y = uh[12:0];
		end
	end

	assign fw = fw_q;
	assign fh = fh_q;
endmodule
`default_nettype wire

FILE: rtl/core/rbr_axis.sv
// source coordinate mapping along one axis, two register stages
`default_nettype none
module rbr_axis #(
	parameter int OUT_SIDE = rbr_pkg::OUT_SIDE_D
) (
	input  wire logic        clk,
	input  wire logic [5:0]  cell_idx,
	input  wire logic [12:0] start,
	input  wire logic [12:0] span,
	input  wire logic [8:0]  size,
	output logic [7:0]       pos0,
	output logic [7:0]       pos1,
	output logic [7:0]       frac
);
	import rbr_pkg::*;

	localparam int DEN = 2 * OUT_SIDE;
	// reciprocal for floor(t/DEN) with t below 2^23
	localparam int RSH = 32;
	localparam longint RECIP = ((64'd1 << RSH) + DEN - 1) / DEN;

	logic [5:0]  cc;
	logic [6:0]  odd;
	logic [22:0] t_s1;
	logic [12:0] start_s1;
	logic [8:0]  size_s1;

	// saturate cell and form numerator
	always_comb begin
		cc  = (32'(cell_idx) >= OUT_SIDE) ? 6'(OUT_SIDE - 1) : cell_idx;
		odd = {cc, 1'b1};
	end

	always_ff @(posedge clk) begin
		t_s1     <= 23'(odd) * 23'({span, 4'd0}) + 23'(OUT_SIDE);
		start_s1 <= start;
		size_s1  <= size;
	end

	logic [52:0] prod;
	logic [20:0] q;
	logic signed [19:0] s;
	logic signed [19:0] hi;
	logic [15:0] sc;

	// divide by constant, clamp to frame
	always_comb begin
		prod = 53'(t_s1) * 53'(RECIP);
		q    = 21'(prod >> RSH);
		s    = $signed({3'd0, start_s1, 4'd0}) + $signed({1'b0, 19'(q)}) - 20'sd128;
		hi   = $signed({3'd0, 9'(size_s1 - 9'd1), 8'd0});
		if (s < 0) sc = '0;
		else if (s > hi) sc = hi[15:0];
		else sc = s[15:0];
	end

	logic [15:0] sc_s2;
	logic [8:0]  size_s2;
	always_ff @(posedge clk) begin
		sc_s2   <= sc;
		size_s2 <= size_s1;
	end

	logic [8:0] nxt;
	always_comb begin
		nxt  = {1'b0, sc_s2[15:8]} + 9'd1;
		pos0 = sc_s2[15:8];
		frac = sc_s2[7:0];
		pos1 = (nxt < size_s2) ? nxt[7:0] : 8'(size_s2 - 9'd1);
	end
endmodule
`default_nettype wire

FILE: rtl/core/rbr_store.sv
// pixel store in four banks by row and column parity, one read of each a cycle
`default_nettype none
module rbr_store #(
	parameter int MAX_WIDTH  = rbr_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = rbr_pkg::MAX_HEIGHT_D
) (
	input  wire logic        clk,
	input  wire logic        we,
	input  wire logic [7:0]  wcol,
	input  wire logic [7:0]  wrow,
	input  wire logic [23:0] wdata,
	input  wire logic [7:0]  x0,
	input  wire logic [7:0]  x1,
	input  wire logic [7:0]  y0,
	input  wire logic [7:0]  y1,
	output logic [23:0]      p00,
	output logic [23:0]      p10,
	output logic [23:0]      p01,
	output logic [23:0]      p11
);
	import rbr_pkg::*;

	localparam int BD = (MAX_WIDTH * MAX_HEIGHT) / 4;
	localparam int AW = $clog2(BD);

	logic [23:0] b0 [BD];
	logic [23:0] b1 [BD];
	logic [23:0] b2 [BD];
	logic [23:0] b3 [BD];

	function automatic logic [AW-1:0] baddr(input logic [7:0] c, input logic [7:0] r);
		return AW'(r[7:1]) * AW'(MAX_WIDTH / 2) + AW'(c[7:1]);
	endfunction

	// bank writes
	always_ff @(posedge clk) begin
		if (we) begin
			case ({wrow[0], wcol[0]})
				2'd0: b0[baddr(wcol, wrow)] <= wdata;
				2'd1: b1[baddr(wcol, wrow)] <= wdata;
				2'd2: b2[baddr(wcol, wrow)] <= wdata;
				default: b3[baddr(wcol, wrow)] <= wdata;
			endcase
		end
	end

	// each bank serves the neighbour with matching parity
	logic [7:0] ce, co, re, ro;
	always_comb begin
		ce = x0[0] ? x1 : x0; co = x0[0] ? x0 : x1;
		re = y0[0] ? y1 : y0; ro = y0[0] ? y0 : y1;
	end

	logic [23:0] d0, d1, d2, d3;
	logic        sx, sy, dx, dy;
	always_ff @(posedge clk) begin
		d0 <= b0[baddr(ce, re)];
		d1 <= b1[baddr(co, re)];
		d2 <= b2[baddr(ce, ro)];
		d3 <= b3[baddr(co, ro)];
		sx <= x0[0];
		sy <= y0[0];
		dx <= (x1 == x0);
		dy <= (y1 == y0);
	end

	logic [23:0] r00, r10, r01, r11;
	always_comb begin
		r00 = sy ? (sx ? d3 : d2) : (sx ? d1 : d0);
		r10 = sy ? (sx ? d2 : d3) : (sx ? d0 : d1);
		r01 = sy ? (sx ? d1 : d0) : (sx ? d3 : d2);
		r11 = sy ? (sx ? d0 : d1) : (sx ? d2 : d3);
		// a neighbour clamped onto the base pixel takes the base pixel data
		p00 = r00;
		p10 = dx ? r00 : r10;
		p01 = dy ? r00 : r01;
		p11 = dy ? (dx ? r00 : r10) : (dx ? r01 : r11);
	end
endmodule
`default_nettype wire

FILE: rtl/core/rbr_interp.sv
// per channel bilinear blend and scaling to Q1.15, three stages
`default_nettype none
module rbr_interp (
	input  wire logic        clk,
	input  wire logic [7:0]  c00,
	input  wire logic [7:0]  c10,
	input  wire logic [7:0]  c01,
	input  wire logic [7:0]  c11,
	input  wire logic [7:0]  fx,
	input  wire logic [7:0]  fy,
	output logic [15:0]      q15
);
	logic [16:0] top_s1, bot_s1;
	logic [7:0]  fy_s1;
	logic [8:0]  gx;
	always_comb gx = 9'd256 - {1'b0, fx};

	// horizontal blend
	always_ff @(posedge clk) begin
		top_s1 <= 17'(c00) * 17'(gx) + 17'(c10) * 17'(fx);
		bot_s1 <= 17'(c01) * 17'(gx) + 17'(c11) * 17'(fx);
		fy_s1  <= fy;
	end

	logic [8:0]  gy;
	logic [24:0] v_s2;
	always_comb gy = 9'd256 - {1'b0, fy_s1};

	// vertical blend
	always_ff @(posedge clk) v_s2 <= 25'(top_s1) * 25'(gy) + 25'(bot_s1) * 25'(fy_s1);

	// floor((v+255)/510) by reciprocal, exact for v+255 below 2^25
	localparam longint RECIP = ((64'd1 << 34) + 509) / 510;
	logic [25:0] n;
	logic [59:0] p;
	always_comb begin
		n = {1'b0, v_s2} + 26'd255;
		p = 60'(n) * 60'(RECIP);
	end
	always_ff @(posedge clk) q15 <= 16'(p >> 34);
endmodule
`default_nettype wire

FILE: rtl/core/roi_bilinear_resize_36.sv
// top level of the roi bilinear crop and resize block
// a sample request gives its result on done through the mapping, store read, blend and output registers
// throughput: one request per cycle, loads and samples in any mix
// store reads use four parity banks, so the four neighbours are read in the same cycle
// reset clears config registers and valid bits; data registers and the pixel store are not cleared
// the receiver cannot stall, each result shows for one cycle on done
`default_nettype none
module roi_bilinear_resize_36 #(
	parameter int MAX_WIDTH  = rbr_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = rbr_pkg::MAX_HEIGHT_D,
	parameter int OUT_SIDE   = rbr_pkg::OUT_SIDE_D
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          req_type,
	input  wire logic [7:0]                    pixel_col,
	input  wire logic [7:0]                    pixel_row,
	input  wire logic [7:0]                    red_in,
	input  wire logic [7:0]                    green_in,
	input  wire logic [7:0]                    blue_in,
	input  wire logic [5:0]                    cell_col,
	input  wire logic [5:0]                    cell_row,
	input  wire logic                          cfg_we,
	input  wire logic [rbr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rbr_pkg::CFG_W-1:0]     cfg_data,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [15:0]                        red_out,
	output logic [15:0]                        green_out,
	output logic [15:0]                        blue_out,
	output logic [12:0]                        used_left,
	output logic [12:0]                        used_top,
	output logic [12:0]                        used_span_x,
	output logic [12:0]                        used_span_y
);
	import rbr_pkg::*;

	localparam int LAT = 7;

	assign busy = 1'b0;

	region_t    region;
	logic [8:0] fw, fh;

	rbr_region #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_region (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .region, .fw, .fh
	);

	logic acc, load_ok;
	assign acc = start && !busy;
	assign load_ok = acc && (req_type == REQ_LOAD) &&
		(32'(pixel_col) < MAX_WIDTH) && (32'(pixel_row) < MAX_HEIGHT);

	// loads pass through the s1 and s2 registers to reach the store in step with the sample reads
	logic        ld_s1, ld_s2;
	logic [7:0]  lcol_s1, lcol_s2, lrow_s1, lrow_s2;
	logic [23:0] lpix_s1, lpix_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_s1 <= 1'b0;
			ld_s2 <= 1'b0;
		end else begin
			ld_s1 <= load_ok;
			ld_s2 <= ld_s1;
		end
	end
	always_ff @(posedge clk) begin
		lcol_s1 <= pixel_col;
		lrow_s1 <= pixel_row;
		lpix_s1 <= {red_in, green_in, blue_in};
		lcol_s2 <= lcol_s1;
		lrow_s2 <= lrow_s1;
		lpix_s2 <= lpix_s1;
	end

	// coordinate stages
	logic [7:0] x0, x1, fx, y0, y1, fy;
	rbr_axis #(.OUT_SIDE(OUT_SIDE)) u_ax (
		.clk, .cell_idx(cell_col), .start(region.left), .span(region.span_x), .size(fw),
		.pos0(x0), .pos1(x1), .frac(fx)
	);
	rbr_axis #(.OUT_SIDE(OUT_SIDE)) u_ay (
		.clk, .cell_idx(cell_row), .start(region.top), .span(region.span_y), .size(fh),
		.pos0(y0), .pos1(y1), .frac(fy)
	);

	logic [23:0] p00, p10, p01, p11;
	rbr_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_store (
		.clk, .we(ld_s2), .wcol(lcol_s2), .wrow(lrow_s2), .wdata(lpix_s2),
		.x0, .x1, .y0, .y1, .p00, .p10, .p01, .p11
	);

	// weights are registered to line up with the store read
	logic [7:0] fx_s3, fy_s3;
	always_ff @(posedge clk) begin
		fx_s3 <= fx;
		fy_s3 <= fy;
	end

	logic [15:0] qr, qg, qb;
	rbr_interp u_ir (.clk, .c00(p00[23:16]), .c10(p10[23:16]), .c01(p01[23:16]),
		.c11(p11[23:16]), .fx(fx_s3), .fy(fy_s3), .q15(qr));
	rbr_interp u_ig (.clk, .c00(p00[15:8]), .c10(p10[15:8]), .c01(p01[15:8]),
		.c11(p11[15:8]), .fx(fx_s3), .fy(fy_s3), .q15(qg));
	rbr_interp u_ib (.clk, .c00(p00[7:0]), .c10(p10[7:0]), .c01(p01[7:0]),
		.c11(p11[7:0]), .fx(fx_s3), .fy(fy_s3), .q15(qb));

	// valid bits and region travel alongside the data
	logic    vld_q [LAT-1];
	region_t reg_q [LAT-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT-1; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= acc && (req_type == REQ_SAMPLE);
			for (int i = 1; i < LAT-1; i++) vld_q[i] <= vld_q[i-1];
		end
	end
	always_ff @(posedge clk) begin
		reg_q[0] <= region;
		for (int i = 1; i < LAT-1; i++) reg_q[i] <= reg_q[i-1];
	end

	// output fields, zero unless status is ok
	logic ok;
	assign ok          = (reg_q[LAT-2].status == ST_OK);
	logic [15:0] r_q, g_q, b_q;
	region_t     o_q;
	logic        done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= vld_q[LAT-2];
	end
	always_ff @(posedge clk) begin
		r_q <= ok ? qr : 16'd0;
		g_q <= ok ? qg : 16'd0;
		b_q <= ok ? qb : 16'd0;
		o_q <= reg_q[LAT-2];
	end

	assign done        = done_q;
	assign status      = o_q.status;
	assign red_out     = r_q;
	assign green_out   = g_q;
	assign blue_out    = b_q;
	assign used_left   = o_q.left;
	assign used_top    = o_q.top;
	assign used_span_x = o_q.span_x;
	assign used_span_y = o_q.span_y;
endmodule
`default_nettype wire

FILE: rtl/core/rbr_checker.sv
// port checker for the roi bilinear resize block, bound to the top level
`default_nettype none
module rbr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        req_type,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [15:0] red_out,
	input wire logic [12:0] used_span_x
);
	import rbr_pkg::*;

	// a result follows a sample request after the fixed latency
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_SAMPLE) |-> ##7 done)
		else $error("sample request lost");
	// loads give no result
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_LOAD) |-> ##7 !done)
		else $error("load produced a result");
	// failed status carries zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (red_out == 16'd0 && used_span_x == 13'd0))
		else $error("fields not cleared on error");
	// channel range
	a_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red_out <= 16'd32768))
		else $error("channel out of range");
endmodule

bind roi_bilinear_resize_36 rbr_checker u_rbr_checker (
	.clk, .arst_n, .start, .busy, .req_type, .done, .status, .red_out, .used_span_x
);
`default_nettype wire
